### hdl/slbm_pkg.sv
// Shared types and constants of the stage latency budget monitor.
package slbm_pkg;

    // Sizes of the stage set and of one average
    localparam int STAGE_COUNT = 8;
    localparam int AVG_BITS    = 32;
    localparam int IDX_BITS    = $clog2(STAGE_COUNT);
    localparam int CNT_BITS    = 4;
    localparam int MULT_BITS   = 8;
    localparam int PROD_BITS   = AVG_BITS + MULT_BITS;
    localparam int ENTRY_BITS  = CNT_BITS + AVG_BITS;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [IDX_BITS-1:0] LAST_IDX  = IDX_BITS'(STAGE_COUNT - 1);
    localparam logic [CNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [AVG_BITS-1:0] AVG_MAX   = '1;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_BITS-1:0] REG_MULTIPLIER = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR      = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_WARMUP     = 2'd2;

    // Register reset values
    localparam logic [MULT_BITS-1:0] MULT_RESET   = 8'd6;
    localparam logic [AVG_BITS-1:0]  FLOOR_RESET  = 32'd5000;
    localparam logic [CNT_BITS-1:0]  WARMUP_RESET = 4'd5;

    // Item actions
    localparam logic ACT_DETECT  = 1'b0;
    localparam logic ACT_WITNESS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [MULT_BITS-1:0] multiplier;
        logic [AVG_BITS-1:0]  min_budget;
        logic [CNT_BITS-1:0]  warmup_target;
    } t_cfg;

    // Per-item command held while the stages are visited
    typedef struct packed {
        logic                start;
        logic                witness;
        logic                fresh_detect;
        logic [IDX_BITS-1:0] frozen_idx;
    } t_cmd;

    // One stage visit entering the evaluation pipeline
    typedef struct packed {
        logic                vld;
        logic [IDX_BITS-1:0] idx;
        logic [AVG_BITS-1:0] avg;
    } t_issue;

    // Write-back towards the stage memory
    typedef struct packed {
        logic                  en;
        logic [IDX_BITS-1:0]   addr;
        logic [ENTRY_BITS-1:0] data;
    } t_wr;

    // Summary of one item once every stage has been visited
    typedef struct packed {
        logic                done;
        logic                found;
        logic                chk_over;
        logic [IDX_BITS-1:0] worst_idx;
        logic [AVG_BITS-1:0] worst_avg;
        logic [AVG_BITS-1:0] worst_bud;
    } t_res;

endpackage

### hdl/slbm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module slbm_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 8
) (
    input  logic                                        i_clk,
    input  logic                                        i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                            i_wr_data,
    input  logic                                        i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                            o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/slbm_eval.sv
// Per-stage evaluation pipeline: warm-up update, budget, over-budget search.
module slbm_eval (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  slbm_pkg::t_cfg                     i_cfg,
    input  slbm_pkg::t_cmd                     i_cmd,
    input  slbm_pkg::t_issue                   i_issue,
    input  logic [slbm_pkg::ENTRY_BITS-1:0]    i_ram_q,
    output slbm_pkg::t_wr                      o_wr,
    output slbm_pkg::t_res                     o_res
);
    import slbm_pkg::*;

    typedef struct packed {
        logic                vld;
        logic [IDX_BITS-1:0] idx;
        logic [AVG_BITS-1:0] avg;
        logic [AVG_BITS-1:0] base;
    } t_s1;

    typedef struct packed {
        logic                vld;
        logic [IDX_BITS-1:0] idx;
        logic [AVG_BITS-1:0] avg;
        logic [AVG_BITS-1:0] bud;
    } t_s2;

    t_issue                r_s0;
    t_s1                   r_s1, n_s1;
    t_s2                   r_s2, n_s2;
    logic [STAGE_COUNT-1:0] r_entry_vld;

    logic                  r_done;
    logic                  r_found;
    logic                  r_chk_over;
    logic [IDX_BITS-1:0]   r_worst_idx;
    logic [AVG_BITS-1:0]   r_worst_avg;
    logic [AVG_BITS-1:0]   r_worst_bud;
    logic [AVG_BITS-1:0]   r_worst_excess;

    logic [AVG_BITS-1:0]   cur_base;
    logic [CNT_BITS-1:0]   cur_cnt;
    logic [CNT_BITS-1:0]   new_cnt;
    logic [AVG_BITS-1:0]   new_base;
    logic                  warming;
    logic [PROD_BITS-1:0]  product;
    logic [AVG_BITS-1:0]   sat_prod;
    logic                  over;
    logic [AVG_BITS-1:0]   over_by;

    // Align the issued visit with the memory read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0.vld <= 1'b0;
        end else begin
            r_s0.vld <= i_issue.vld;
        end
        r_s0.idx <= i_issue.idx;
        r_s0.avg <= i_issue.avg;
    end

    // Warm-up: count nonzero ticks and latch the baseline at the target
    always_comb begin
        cur_base = r_entry_vld[r_s0.idx] ? i_ram_q[AVG_BITS-1:0] : '0;
        cur_cnt  = r_entry_vld[r_s0.idx] ? i_ram_q[ENTRY_BITS-1:AVG_BITS] : '0;
        warming  = !i_cmd.witness && (cur_base == '0) && (r_s0.avg != '0);
        new_cnt  = cur_cnt;
        new_base = cur_base;
        if (warming) begin
            if (cur_cnt != COUNT_MAX) begin
                new_cnt = cur_cnt + 1'b1;
            end
            if (new_cnt >= i_cfg.warmup_target) begin
                new_base = r_s0.avg;
            end
        end
        o_wr.en   = r_s0.vld && !i_cmd.witness;
        o_wr.addr = r_s0.idx;
        o_wr.data = {new_cnt, new_base};
        n_s1.vld  = r_s0.vld;
        n_s1.idx  = r_s0.idx;
        n_s1.avg  = r_s0.avg;
        n_s1.base = new_base;
    end

    // Mark entries that hold written data; unwritten ones read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_vld <= '0;
        end else if (o_wr.en) begin
            r_entry_vld[o_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.vld <= 1'b0;
        end else begin
            r_s1.vld <= n_s1.vld;
        end
        r_s1.idx  <= n_s1.idx;
        r_s1.avg  <= n_s1.avg;
        r_s1.base <= n_s1.base;
    end

    // Budget: baseline times multiplier, saturated, raised to the floor; zero while no baseline
    always_comb begin
        product  = r_s1.base * PROD_BITS'(i_cfg.multiplier);
        sat_prod = (product[PROD_BITS-1:AVG_BITS] != '0) ? AVG_MAX
                                                         : product[AVG_BITS-1:0];
        n_s2.vld = r_s1.vld;
        n_s2.idx = r_s1.idx;
        n_s2.avg = r_s1.avg;
        if (r_s1.base == '0) begin
            n_s2.bud = '0;
        end else if (sat_prod < i_cfg.min_budget) begin
            n_s2.bud = i_cfg.min_budget;
        end else begin
            n_s2.bud = sat_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.vld <= 1'b0;
        end else begin
            r_s2.vld <= n_s2.vld;
        end
        r_s2.idx <= n_s2.idx;
        r_s2.avg <= n_s2.avg;
        r_s2.bud <= n_s2.bud;
    end

    // Over-budget test and worst-stage search; ties keep the lower index
    assign over    = (r_s2.bud != '0) && (r_s2.avg > r_s2.bud);
    assign over_by = r_s2.avg - r_s2.bud;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_done <= r_s2.vld && (r_s2.idx == LAST_IDX);
            if (i_cmd.start) begin
                r_found <= 1'b0;
            end else if (r_s2.vld && i_cmd.fresh_detect && over
                         && (!r_found || over_by > r_worst_excess)) begin
                r_found <= 1'b1;
            end
        end
        if (r_s2.vld && i_cmd.fresh_detect && over
            && (!r_found || over_by > r_worst_excess)) begin
            r_worst_idx    <= r_s2.idx;
            r_worst_avg    <= r_s2.avg;
            r_worst_bud    <= r_s2.bud;
            r_worst_excess <= over_by;
        end
        if (r_s2.vld && (r_s2.idx == i_cmd.frozen_idx)) begin
            r_chk_over <= over;
        end
    end

    assign o_res.done      = r_done;
    assign o_res.found     = r_found;
    assign o_res.chk_over  = r_chk_over;
    assign o_res.worst_idx = r_worst_idx;
    assign o_res.worst_avg = r_worst_avg;
    assign o_res.worst_bud = r_worst_bud;

endmodule

### hdl/stage_latency_budget_monitor.sv
// Top level of the stage latency budget monitor: sequencer, memory and result register.
//
// Each accepted item passes these steps before the next one is accepted: capture of
// the averages, one memory visit per stage through the shared warm-up, multiply and
// compare pipeline, a drain of that pipeline and its search register, and a last step
// that updates the frozen episode state and loads the result register. That last step
// repeats while an earlier result is still held and the receiver is not ready. The
// per-stage baseline and warm-up count live in one 8-entry memory with registered read
// data; reset clears them at once through per-entry valid bits, so no clearing pass is
// needed. A finished result waits in its own register, so the next item may be taken
// while the previous result is still held. Configuration writes land at once and must
// only be issued while the block is idle.
module stage_latency_budget_monitor (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // configuration write port
    input  logic                                  i_cfg_wr_en,
    input  logic [slbm_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [31:0]                           i_cfg_data,
    // input items
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_action,
    input  logic                                  i_episode_active,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage0_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage1_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage2_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage3_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage4_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage5_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage6_avg_us,
    input  logic [slbm_pkg::AVG_BITS-1:0]         i_stage7_avg_us,
    // result items
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_verdict,
    output logic                                  o_frozen_valid,
    output logic [slbm_pkg::IDX_BITS-1:0]         o_frozen_stage,
    output logic [slbm_pkg::AVG_BITS-1:0]         o_snapshot_avg_us,
    output logic [slbm_pkg::AVG_BITS-1:0]         o_snapshot_budget_us
);
    import slbm_pkg::*;

    t_state                r_state, n_state;
    t_cfg                  r_cfg;
    logic [IDX_BITS-1:0]   r_cnt;
    logic [AVG_BITS-1:0]   r_avg [STAGE_COUNT];
    logic                  r_action;
    logic                  r_episode;

    logic                  r_frozen_flag;
    logic [IDX_BITS-1:0]   r_frozen_idx;
    logic [AVG_BITS-1:0]   r_snap_avg;
    logic [AVG_BITS-1:0]   r_snap_bud;

    logic                  r_out_valid;
    logic                  r_out_verdict;

    logic                  accept;
    logic                  load_out;
    logic                  verdict;
    logic                  freeze;
    t_cmd                  cmd;
    t_issue                issue;
    t_wr                   wr;
    t_res                  res;
    logic [ENTRY_BITS-1:0] ram_q;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.multiplier    <= MULT_RESET;
            r_cfg.min_budget    <= FLOOR_RESET;
            r_cfg.warmup_target <= WARMUP_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                REG_MULTIPLIER: r_cfg.multiplier    <= i_cfg_data[MULT_BITS-1:0];
                REG_FLOOR:      r_cfg.min_budget    <= i_cfg_data[AVG_BITS-1:0];
                REG_WARMUP:     r_cfg.warmup_target <= i_cfg_data[CNT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer: next state and handshake
    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (res.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign accept = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_cnt <= '0;
            end else if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // Capture the item on transfer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_episode <= i_episode_active;
            r_avg[0]  <= i_stage0_avg_us;
            r_avg[1]  <= i_stage1_avg_us;
            r_avg[2]  <= i_stage2_avg_us;
            r_avg[3]  <= i_stage3_avg_us;
            r_avg[4]  <= i_stage4_avg_us;
            r_avg[5]  <= i_stage5_avg_us;
            r_avg[6]  <= i_stage6_avg_us;
            r_avg[7]  <= i_stage7_avg_us;
        end
    end

    // Issue one stage visit per cycle while running
    always_comb begin
        issue.vld = (r_state == ST_RUN);
        issue.idx = r_cnt;
        issue.avg = r_avg[r_cnt];

        cmd.start        = accept;
        cmd.witness      = (r_action == ACT_WITNESS);
        cmd.fresh_detect = (r_action == ACT_DETECT) && !r_episode;
        cmd.frozen_idx   = r_frozen_idx;
    end

    slbm_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (STAGE_COUNT)
    ) u_stage_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr.en),
        .i_wr_addr (wr.addr),
        .i_wr_data (wr.data),
        .i_rd_en   (issue.vld),
        .i_rd_addr (issue.idx),
        .o_rd_data (ram_q)
    );

    slbm_eval u_eval (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .i_issue (issue),
        .i_ram_q (ram_q),
        .o_wr    (wr),
        .o_res   (res)
    );

    // Verdict for the finished item
    always_comb begin
        freeze = 1'b0;
        if (r_action == ACT_WITNESS) begin
            verdict = !r_frozen_flag || !res.chk_over;
        end else if (r_episode) begin
            verdict = r_frozen_flag && res.chk_over;
        end else begin
            verdict = res.found;
            freeze  = res.found;
        end
    end

    // Episode subject: replace only on a fresh freeze
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frozen_flag <= 1'b0;
            r_frozen_idx  <= '0;
            r_snap_avg    <= '0;
            r_snap_bud    <= '0;
        end else if (load_out && freeze) begin
            r_frozen_flag <= 1'b1;
            r_frozen_idx  <= res.worst_idx;
            r_snap_avg    <= res.worst_avg;
            r_snap_bud    <= res.worst_bud;
        end
    end

    // Result register: hold until transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load_out) begin
            r_out_verdict <= verdict;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_verdict            = r_out_verdict;
    assign o_frozen_valid       = r_frozen_flag;
    assign o_frozen_stage       = r_frozen_idx;
    assign o_snapshot_avg_us    = r_snap_avg;
    assign o_snapshot_budget_us = r_snap_bud;

endmodule
